[hdl/assert_macros.svh]
// Assertion macros shared by the display framer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition a implies condition b in the same cycle.
`define FDSDF_ASSERT_NOW(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("framer check failed");

// Condition a implies condition b in the next cycle.
`define FDSDF_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("framer check failed");

`endif

[hdl/fdsdf_pkg.sv]
// Types, constants and helper functions of the four-digit display framer.
package fdsdf_pkg;

    // Request operations.
    localparam logic OP_SHOW = 1'b0;
    localparam logic OP_INIT = 1'b1;

    // Command and address bytes.
    localparam logic [7:0] CMD_DISPLAY_CTRL = 8'h88;
    localparam logic [7:0] CMD_DATA_FIXED   = 8'h44;
    localparam logic [7:0] ADDR_BASE        = 8'hC0;
    localparam logic [7:0] BLANK_CODE       = 8'h00;

    // Saturation limit and decimal weights.
    localparam logic [15:0] VALUE_MAX = 16'd9999;
    localparam logic [13:0] WEIGHT_THOUSANDS = 14'd1000;
    localparam logic [13:0] WEIGHT_HUNDREDS  = 14'd100;
    localparam logic [13:0] WEIGHT_TENS      = 14'd10;

    // Last byte index of each request kind.
    localparam logic [3:0] SHOW_LAST_IDX = 4'd7;
    localparam logic [3:0] INIT_LAST_IDX = 4'd9;

    // Queue between front and back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Seven-segment codes for digits 0 to 9.
    localparam logic [9:0][7:0] SEG_TABLE = {
        8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    typedef struct packed {
        logic        op;
        logic [15:0] value;
    } in_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       opens_frame;
        logic       closes_frame;
        logic       last;
    } out_t;

    // One classified request: kind and the segment byte of each position.
    typedef struct packed {
        logic            op;
        logic [3:0][7:0] codes;
    } q_entry_t;

    typedef struct packed {
        logic [3:0]  digit;
        logic [13:0] rem;
    } digit_step_t;

    // Extracts one decimal digit of a value below ten times the weight.
    function automatic digit_step_t digit_step(input logic [13:0] value,
                                               input logic [13:0] weight);
        digit_step_t r;
        logic [13:0] acc;
        r.digit = 4'd0;
        r.rem   = value;
        acc     = 14'd0;
        for (int d = 1; d <= 9; d++)
        begin
            acc = acc + weight;
            if (value >= acc)
            begin
                r.digit = 4'(d);
                r.rem   = value - acc;
            end
        end
        return r;
    endfunction

    // Segment code of a decimal digit; digits above nine give the blank code.
    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        if (digit <= 4'd9)
            code = SEG_TABLE[digit];
        else
            code = BLANK_CODE;
        return code;
    endfunction

endpackage

[hdl/four_digit_segment_display_framer.sv]
// A request passes the three digit stages, the queue and the back-end request register;
// then its first byte goes to the output register. A show request sends 8 bytes and an
// initialize request 10, one per cycle unless out_ready stalls; the sequencer takes the
// next request with its last byte; front end and two-entry queue let requests stack up.
// Reset (rst_n, asynchronous, active low) empties all stages and sets brightness to 0.
`include "assert_macros.svh"

module four_digit_segment_display_framer
    import fdsdf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_t        in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output out_t       out_item,
    input  logic       cfg_we,
    input  logic [2:0] cfg_wdata
);

    logic [2:0] brightness_reg;
    logic       push_valid;
    logic       push_ready;
    q_entry_t   push_entry;
    logic       rd_valid;
    logic       rd_ready;
    q_entry_t   rd_entry;

    // Brightness register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            brightness_reg <= 3'd0;
        else if (cfg_we)
            brightness_reg <= cfg_wdata;
    end

    fdsdf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    fdsdf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_entry (push_entry),
        .rd_valid (rd_valid),
        .rd_ready (rd_ready),
        .rd_entry (rd_entry)
    );

    fdsdf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .brightness (brightness_reg),
        .rd_valid   (rd_valid),
        .rd_ready   (rd_ready),
        .rd_entry   (rd_entry),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_item   (out_item)
    );

    // The final byte of a request always ends a frame.
    `FDSDF_ASSERT_NOW(a_last_closes, clk, rst_n, out_valid && out_item.last, out_item.closes_frame)

    // A byte that opens a frame left open is a position address.
    `FDSDF_ASSERT_NOW(a_addr_byte, clk, rst_n,
        out_valid && out_item.opens_frame && !out_item.closes_frame,
        out_item.byte_value[7:2] == 6'b110000)

    // A single-byte frame carries one of the two commands.
    `FDSDF_ASSERT_NOW(a_cmd_byte, clk, rst_n,
        out_valid && out_item.opens_frame && out_item.closes_frame,
        (out_item.byte_value == CMD_DATA_FIXED) || (out_item.byte_value[7:3] == 5'b10001))

    // A byte that is not the last of its run is followed by another byte.
    `FDSDF_ASSERT_NEXT(a_run_continues, clk, rst_n,
        out_valid && out_ready && !out_item.last, out_valid)

endmodule

[hdl/fdsdf_front.sv]
// Front end: accepts requests and converts the value to segment codes over three stages.
module fdsdf_front
    import fdsdf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_t      in_item,
    output logic     push_valid,
    input  logic     push_ready,
    output q_entry_t push_entry
);

    logic        s1_valid_reg;
    logic        s1_op_reg;
    logic [13:0] s1_rem_reg;

    logic        s2_valid_reg;
    logic        s2_op_reg;
    logic [3:0]  s2_d0_reg;
    logic [9:0]  s2_rem_reg;

    logic        s3_valid_reg;
    logic        s3_op_reg;
    logic [7:0]  s3_code0_reg;
    logic [7:0]  s3_code1_reg;
    logic        s3_nz_reg;
    logic [6:0]  s3_rem_reg;

    logic        s1_ready;
    logic        s2_ready;
    logic        s3_ready;
    logic [13:0] sat_value;
    digit_step_t ds_thousands;
    digit_step_t ds_hundreds;
    digit_step_t ds_tens;
    logic        s2_nz;

    // Stage handshake: a stage moves when it is empty or its successor takes it.
    assign s3_ready = !s3_valid_reg || push_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Saturate the value at 9999.
    assign sat_value = (in_item.value > VALUE_MAX) ? VALUE_MAX[13:0] : in_item.value[13:0];

    // Digit extraction, one digit per stage.
    assign ds_thousands = digit_step(s1_rem_reg, WEIGHT_THOUSANDS);
    assign ds_hundreds  = digit_step({4'b0, s2_rem_reg}, WEIGHT_HUNDREDS);
    assign ds_tens      = digit_step({7'b0, s3_rem_reg}, WEIGHT_TENS);
    assign s2_nz        = (s2_d0_reg != 4'd0) || (ds_hundreds.digit != 4'd0);

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_op_reg  <= in_item.op;
            s1_rem_reg <= sat_value;
        end
        if (s2_ready)
        begin
            s2_op_reg  <= s1_op_reg;
            s2_d0_reg  <= ds_thousands.digit;
            s2_rem_reg <= ds_thousands.rem[9:0];
        end
        if (s3_ready)
        begin
            s3_op_reg    <= s2_op_reg;
            s3_code0_reg <= (s2_d0_reg != 4'd0) ? seg_code(s2_d0_reg) : BLANK_CODE;
            s3_code1_reg <= s2_nz ? seg_code(ds_hundreds.digit) : BLANK_CODE;
            s3_nz_reg    <= s2_nz;
            s3_rem_reg   <= ds_hundreds.rem[6:0];
        end
    end

    // Final digits and queue entry; initialize blanks every position.
    always_comb
    begin
        push_entry.op = s3_op_reg;
        if (s3_op_reg == OP_INIT)
        begin
            push_entry.codes = {4{BLANK_CODE}};
        end
        else
        begin
            push_entry.codes[0] = s3_code0_reg;
            push_entry.codes[1] = s3_code1_reg;
            push_entry.codes[2] = (s3_nz_reg || (ds_tens.digit != 4'd0)) ?
                                  seg_code(ds_tens.digit) : BLANK_CODE;
            push_entry.codes[3] = seg_code(ds_tens.rem[3:0]);
        end
    end

    assign push_valid = s3_valid_reg;

endmodule

[hdl/fdsdf_queue.sv]
// Small register queue between the front end and the byte sequencer.
module fdsdf_queue
    import fdsdf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_valid,
    output logic     wr_ready,
    input  q_entry_t wr_entry,
    output logic     rd_valid,
    input  logic     rd_ready,
    output q_entry_t rd_entry
);

    q_entry_t             mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg;
    logic [QUEUE_AW-1:0]  rd_ptr_reg;
    logic [QUEUE_AW:0]    count_reg;
    logic                 do_wr;
    logic                 do_rd;

    assign wr_ready = (count_reg != QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_entry = mem_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 :
                              wr_ptr_reg + QUEUE_AW'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 :
                              rd_ptr_reg + QUEUE_AW'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + (QUEUE_AW+1)'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - (QUEUE_AW+1)'(1);
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule

[hdl/fdsdf_back.sv]
// Back end: walks one queued request and sends its bytes one per cycle unless out_ready stalls.
module fdsdf_back
    import fdsdf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [2:0] brightness,
    input  logic       rd_valid,
    output logic       rd_ready,
    input  q_entry_t   rd_entry,
    output logic       out_valid,
    input  logic       out_ready,
    output out_t       out_item
);

    q_entry_t   cur_reg;
    logic       cur_valid_reg;
    logic [3:0] idx_reg;
    logic       out_valid_reg;
    out_t       out_reg;

    logic       out_load;
    logic       step;
    logic       fin;
    logic [3:0] last_idx;
    logic [3:0] pos_idx;
    logic [1:0] pos;
    out_t       out_next;

    assign out_load = !out_valid_reg || out_ready;
    assign step     = cur_valid_reg && out_load;
    assign last_idx = (cur_reg.op == OP_INIT) ? INIT_LAST_IDX : SHOW_LAST_IDX;
    assign fin      = step && (idx_reg == last_idx);
    assign rd_ready = !cur_valid_reg || fin;

    // Byte of the current position; initialize runs two command frames first.
    assign pos_idx = (cur_reg.op == OP_INIT) ? idx_reg - 4'd2 : idx_reg;
    assign pos     = pos_idx[2:1];

    always_comb
    begin
        out_next.last = (idx_reg == last_idx);
        if ((cur_reg.op == OP_INIT) && (idx_reg == 4'd0))
        begin
            out_next.byte_value   = CMD_DISPLAY_CTRL | {5'b0, brightness};
            out_next.opens_frame  = 1'b1;
            out_next.closes_frame = 1'b1;
        end
        else if ((cur_reg.op == OP_INIT) && (idx_reg == 4'd1))
        begin
            out_next.byte_value   = CMD_DATA_FIXED;
            out_next.opens_frame  = 1'b1;
            out_next.closes_frame = 1'b1;
        end
        else if (!pos_idx[0])
        begin
            out_next.byte_value   = ADDR_BASE | {6'b0, pos};
            out_next.opens_frame  = 1'b1;
            out_next.closes_frame = 1'b0;
        end
        else
        begin
            out_next.byte_value   = cur_reg.codes[pos];
            out_next.opens_frame  = 1'b0;
            out_next.closes_frame = 1'b1;
        end
    end

    // Current request and byte counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rd_ready && rd_valid)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= 4'd0;
            end
            else if (fin)
            begin
                cur_valid_reg <= 1'b0;
            end
            else if (step)
            begin
                idx_reg <= idx_reg + 4'd1;
            end
            if (out_load)
                out_valid_reg <= cur_valid_reg;
        end
    end

    // Request payload and output register.
    always_ff @(posedge clk)
    begin
        if (rd_ready && rd_valid)
            cur_reg <= rd_entry;
        if (step)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

[test/four_digit_segment_display_framer_test.sv]
// Self-checking testbench for the four-digit seven-segment display byte framer.
`timescale 1ns / 1ps

module four_digit_segment_display_framer_test;
    import fdsdf_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int RESET_CYCLES    = 12;
    localparam int ITEMS_PER_PHASE = 36;
    localparam int SETTLE_CYCLES   = 10;
    localparam int LONG_HOLD       = 120;
    localparam int HOLD_SPACING    = 700;
    localparam int MAX_PRINTED     = 40;

    // Tracks the bytes each request should produce and checks them in order.
    class display_byte_tracker;
        out_t       pending_bytes[$];
        logic [2:0] brightness;
        int         errors;
        int         printed;

        function new();
            brightness = 3'd0;
            errors     = 0;
            printed    = 0;
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (printed < MAX_PRINTED)
            begin
                $display("mismatch: %s", msg);
                printed++;
            end
        endtask

        // Builds the byte run of one accepted request and queues it.
        function void add_request(in_t req);
            out_t        run[10];
            logic [7:0]  codes[4];
            int unsigned shown;
            int unsigned weight;
            int unsigned digit;
            int          count;
            count = 0;
            if (req.op == OP_INIT)
            begin
                run[count] = '{byte_value: CMD_DISPLAY_CTRL | {5'd0, brightness},
                               opens_frame: 1'b1, closes_frame: 1'b1, last: 1'b0};
                count++;
                run[count] = '{byte_value: CMD_DATA_FIXED,
                               opens_frame: 1'b1, closes_frame: 1'b1, last: 1'b0};
                count++;
                for (int p = 0; p < 4; p++)
                    codes[p] = BLANK_CODE;
            end
            else
            begin
                shown  = (req.value > VALUE_MAX) ? int'(VALUE_MAX) : int'(req.value);
                weight = 1000;
                for (int p = 0; p < 4; p++)
                begin
                    digit = (shown / weight) % 10;
                    // Leading zeros are blanked, but the units digit always shows.
                    if (p < 3 && shown < weight)
                        codes[p] = BLANK_CODE;
                    else
                    begin
                        case (digit)
                            0: codes[p] = 8'h3F;
                            1: codes[p] = 8'h06;
                            2: codes[p] = 8'h5B;
                            3: codes[p] = 8'h4F;
                            4: codes[p] = 8'h66;
                            5: codes[p] = 8'h6D;
                            6: codes[p] = 8'h7D;
                            7: codes[p] = 8'h07;
                            8: codes[p] = 8'h7F;
                            default: codes[p] = 8'h6F;
                        endcase
                    end
                    weight = weight / 10;
                end
            end
            // One address frame and one segment frame per position.
            for (int p = 0; p < 4; p++)
            begin
                run[count] = '{byte_value: 8'(ADDR_BASE + p),
                               opens_frame: 1'b1, closes_frame: 1'b0, last: 1'b0};
                count++;
                run[count] = '{byte_value: codes[p],
                               opens_frame: 1'b0, closes_frame: 1'b1, last: 1'b0};
                count++;
            end
            run[count - 1].last = 1'b1;
            for (int i = 0; i < count; i++)
                pending_bytes.push_back(run[i]);
        endfunction

        // Compares one received byte with the oldest queued one.
        task check_byte(out_t got);
            out_t want;
            if (pending_bytes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected byte %02h", got.byte_value));
                return;
            end
            want = pending_bytes.pop_front();
            if (got.byte_value !== want.byte_value)
                report_mismatch($sformatf("byte_value %02h, wanted %02h",
                                          got.byte_value, want.byte_value));
            if (got.opens_frame !== want.opens_frame)
                report_mismatch($sformatf("opens_frame %b, wanted %b on byte %02h",
                                          got.opens_frame, want.opens_frame, want.byte_value));
            if (got.closes_frame !== want.closes_frame)
                report_mismatch($sformatf("closes_frame %b, wanted %b on byte %02h",
                                          got.closes_frame, want.closes_frame,
                                          want.byte_value));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %b, wanted %b on byte %02h",
                                          got.last, want.last, want.byte_value));
        endtask
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    in_t        in_item   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_t       out_item;
    logic       cfg_we    = 1'b0;
    logic [2:0] cfg_wdata = 3'd0;

    display_byte_tracker tracker = new();

    int cycle_count   = 0;
    int received      = 0;
    int hold_left     = 0;
    int next_hold_at  = 400;
    int ready_gap     = 0;
    int sink_mode     = 0;
    int stretch_left  = 0;
    bit sender_steady = 1'b0;

    four_digit_segment_display_framer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Gap length: mostly short, now and then a long one.
    function automatic int random_gap();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // Value mix covering every digit count, the saturation range and boundaries.
    function automatic in_t random_request();
        in_t req;
        req.op = ($urandom_range(0, 99) < 15) ? OP_INIT : OP_SHOW;
        case ($urandom_range(0, 6))
            0: req.value = 16'($urandom_range(0, 9));
            1: req.value = 16'($urandom_range(10, 99));
            2: req.value = 16'($urandom_range(100, 999));
            3: req.value = 16'($urandom_range(1000, 9999));
            4: req.value = 16'($urandom_range(10000, 65535));
            5: req.value = 16'($urandom);
            default:
            begin
                case ($urandom_range(0, 5))
                    0: req.value = 16'd0;
                    1: req.value = 16'd9;
                    2: req.value = 16'd999;
                    3: req.value = 16'd1000;
                    4: req.value = 16'd9999;
                    default: req.value = 16'd10000;
                endcase
            end
        endcase
        return req;
    endfunction

    // Offers one request; starts and ends on a falling edge.
    task offer_request(in_t req);
        int gap;
        gap = 0;
        if (!sender_steady && $urandom_range(0, 99) < 35)
            gap = random_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.add_request(req);
        @(negedge clk);
    endtask

    // Holds the sender until every queued byte has arrived and the pipeline settles.
    task wait_drained();
        in_valid <= 1'b0;
        while (tracker.pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_brightness(logic [2:0] level);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= level;
        @(negedge clk);
        cfg_we <= 1'b0;
        tracker.brightness = level;
    endtask

    // Receiver: checks each transaction and stalls in stretches of varying density.
    always
    begin
        @(posedge clk);
        if (rst_n && out_valid && out_ready)
        begin
            tracker.check_byte(out_item);
            received++;
        end
        @(negedge clk);
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (received >= next_hold_at)
        begin
            // A long hold-off so the block fills up and stalls its input.
            hold_left    = LONG_HOLD - 1;
            next_hold_at = next_hold_at + HOLD_SPACING;
            out_ready   <= 1'b0;
        end
        else
        begin
            if (stretch_left == 0)
            begin
                sink_mode    = $urandom_range(0, 2);
                stretch_left = $urandom_range(20, 200);
            end
            stretch_left--;
            if (ready_gap > 0)
            begin
                ready_gap--;
                out_ready <= 1'b0;
            end
            else if (sink_mode != 0 && $urandom_range(0, 99) < (sink_mode == 1 ? 20 : 50))
            begin
                ready_gap  = random_gap() - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("four_digit_segment_display_framer regression: fail");
            $finish;
        end
    end

    // Main sequence: reset, directed requests, then random phases at several brightness levels.
    initial
    begin
        in_t         directed[$];
        logic [2:0]  levels[5];
        in_t         req;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_brightness(3'd7);
        req.op = OP_INIT;  req.value = 16'd0;      directed.push_back(req);
        req.op = OP_SHOW;  req.value = 16'd0;      directed.push_back(req);
        req.value = 16'd1;     directed.push_back(req);
        req.value = 16'd9;     directed.push_back(req);
        req.value = 16'd10;    directed.push_back(req);
        req.value = 16'd99;    directed.push_back(req);
        req.value = 16'd100;   directed.push_back(req);
        req.value = 16'd999;   directed.push_back(req);
        req.value = 16'd1000;  directed.push_back(req);
        req.value = 16'd9999;  directed.push_back(req);
        req.value = 16'd10000; directed.push_back(req);
        req.value = 16'hFFFF;  directed.push_back(req);
        req.value = 16'hAAAA;  directed.push_back(req);
        req.value = 16'h5555;  directed.push_back(req);
        req.value = 16'd1234;  directed.push_back(req);
        req.value = 16'd5678;  directed.push_back(req);
        req.value = 16'd9090;  directed.push_back(req);
        req.value = 16'd4007;  directed.push_back(req);
        req.op = OP_INIT;  req.value = 16'hFFFF;   directed.push_back(req);
        foreach (directed[i])
            offer_request(directed[i]);
        wait_drained();

        levels[0] = 3'd0;
        levels[1] = 3'd3;
        levels[2] = 3'd7;
        levels[3] = 3'd5;
        levels[4] = 3'($urandom_range(1, 6));
        for (int ph = 0; ph < 5; ph++)
        begin
            write_brightness(levels[ph]);
            // One phase with the sender never idling.
            sender_steady = (ph == 1);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                offer_request(random_request());
            wait_drained();
        end

        if (tracker.errors == 0)
            $display("four_digit_segment_display_framer regression: pass");
        else
            $display("four_digit_segment_display_framer regression: fail");
        $finish;
    end

endmodule

[four_digit_segment_display_framer.f]
+incdir+hdl
hdl/fdsdf_pkg.sv
hdl/fdsdf_front.sv
hdl/fdsdf_queue.sv
hdl/fdsdf_back.sv
hdl/four_digit_segment_display_framer.sv
test/four_digit_segment_display_framer_test.sv
